@@ rtl/core/nmo_pkg.sv @@
// ---------------------------------------------------------------------------
// nmo_pkg: shared widths and codes for the nonhyperbolic moveout pipeline
// Field widths, intermediate word sizes and register codes used by the
// top level and its square root unit.
// ---------------------------------------------------------------------------
`default_nettype none

package nmo_pkg;

	// I/O field widths
	localparam int TIME_W = 24;     // Q8.16 seconds
	localparam int VEL_W  = 24;     // Q16.8 m/s
	localparam int OFS_W  = 24;     // signed Q16.8 m
	localparam int ETA_W  = 16;     // signed Q3.12

	// intermediate words
	localparam int T2_W   = 48;     // t0^2, units of 2^-32 s^2
	localparam int X2_W   = 47;     // offset magnitude squared
	localparam int R_W    = 56;     // x^2/v^2, units of 2^-32 s^2
	localparam int S_W    = 57;     // t0^2 + x^2/v^2
	localparam int SF_W   = 58;     // corrected t^2
	localparam int PART_W = 28;     // operand slice for wide products
	localparam int CMAG_W = 17;     // |4096 + 2*eta|
	localparam int QM_W   = 73;     // |c| * R
	localparam int D_W    = 74;     // correction denominator
	localparam int N_W    = 128;    // correction numerator
	localparam int NP_W   = PART_W + CMAG_W;
	localparam int A_W    = 57;     // clamped correction quotient

	// eta scale and dead band: |code| <= 4 counts as isotropic
	localparam int ETA_ONE      = 4096;
	localparam int ETA_ZERO_MAG = 4;

	// APB register map
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_ETA = '0;

endpackage

`default_nettype wire

@@ rtl/core/nonhyperbolic_moveout_time.sv @@
// ---------------------------------------------------------------------------
// nonhyperbolic_moveout_time: eta-corrected NMO traveltime
// Computes t = sqrt(t0^2 + x^2/v^2 - A) per offset, with the anisotropic
// correction A set by the eta register, saturating on overflow.
// ---------------------------------------------------------------------------
// The block takes one (t0, v, x) transfer per clock while in_ready is high
// and returns one result per input, in order. Its registered stages include
// the two pipelined restoring dividers (x^2/v^2 and the eta correction)
// and the pipelined square root. Every stage has its own valid bit and a stage
// only waits when the one after it is full, so back-pressure on the output
// stops the pipeline without loss and empty slots are filled. Program
// anisotropy_eta (APB offset 0) only while the pipeline is empty.
`default_nettype none

module nonhyperbolic_moveout_time #(
	parameter int DIV_STEPS  = 4,
	parameter int SQRT_STEPS = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [nmo_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [nmo_pkg::DATA_W-1:0]         pwdata,
	output logic [nmo_pkg::DATA_W-1:0]              prdata,
	output logic                                    pready,
	// input channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [nmo_pkg::TIME_W-1:0]         zero_offset_time,
	input  wire logic [nmo_pkg::VEL_W-1:0]          rms_velocity,
	input  wire logic signed [nmo_pkg::OFS_W-1:0]   source_offset,
	input  wire logic                               last_of_gather,
	// output channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [nmo_pkg::TIME_W-1:0]              moveout_time,
	output logic                                    saturated,
	output logic                                    last_out
);

	localparam int TIME_W = nmo_pkg::TIME_W;
	localparam int OFS_W  = nmo_pkg::OFS_W;
	localparam int ETA_W  = nmo_pkg::ETA_W;
	localparam int T2_W   = nmo_pkg::T2_W;
	localparam int X2_W   = nmo_pkg::X2_W;
	localparam int R_W    = nmo_pkg::R_W;
	localparam int S_W    = nmo_pkg::S_W;
	localparam int SF_W   = nmo_pkg::SF_W;
	localparam int PART_W = nmo_pkg::PART_W;
	localparam int CMAG_W = nmo_pkg::CMAG_W;
	localparam int QM_W   = nmo_pkg::QM_W;
	localparam int D_W    = nmo_pkg::D_W;
	localparam int N_W    = nmo_pkg::N_W;
	localparam int NP_W   = nmo_pkg::NP_W;
	localparam int A_W    = nmo_pkg::A_W;
	localparam int ADDR_W = nmo_pkg::ADDR_W;
	localparam int DATA_W = nmo_pkg::DATA_W;
	localparam int NPARTS = N_W / PART_W;       // numerator slices of R^2
	localparam int R2_W   = 2 * R_W;
	localparam int RDN_W  = N_W - A_W;          // numerator bits above the quotient
	localparam int SD1_W  = T2_W + 2;
	localparam int SD2_W  = S_W + 4;

	// ------------------------------------------------------------------
	// configuration register
	// ------------------------------------------------------------------
	logic [ETA_W-1:0] eta_q;
	logic             reg_hit;

	assign reg_hit = (paddr[ADDR_W-1:2] == nmo_pkg::REG_ETA);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? DATA_W'(eta_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_q <= '0;
		end else if (psel && penable && pwrite && reg_hit) begin
			eta_q <= pwdata[ETA_W-1:0];
		end
	end

	// eta derived terms; the user must keep them static while items are in flight, the block does not enforce it
	logic                    eta_neg;
	logic [ETA_W-1:0]        eta_abs;
	logic                    eta_act;
	logic [CMAG_W-1:0]       emag2;
	logic signed [ETA_W+1:0] c_coef;
	logic                    c_neg;
	logic [CMAG_W-1:0]       cmag;

	assign eta_neg = eta_q[ETA_W-1];
	assign eta_abs = eta_neg ? ETA_W'(-eta_q) : eta_q;
	assign eta_act = eta_abs > ETA_W'(nmo_pkg::ETA_ZERO_MAG);
	assign emag2   = {eta_abs, 1'b0};
	assign c_coef  = $signed((ETA_W+2)'(nmo_pkg::ETA_ONE))
		+ $signed({eta_q[ETA_W-1], eta_q, 1'b0});
	assign c_neg   = c_coef[ETA_W+1];
	assign cmag    = c_neg ? CMAG_W'(-c_coef) : CMAG_W'(c_coef);

	// ------------------------------------------------------------------
	// stage 1: squares of t0, |x| and v
	// ------------------------------------------------------------------
	logic              rdy_s1;
	logic              vld_s1;
	logic [T2_W-1:0]   t2_s1;
	logic [X2_W-1:0]   x2_s1;
	logic [T2_W-1:0]   v2_s1;
	logic              last_s1;
	logic [OFS_W-1:0]  xmag;
	logic              d1_in_ready;

	assign xmag     = source_offset[OFS_W-1] ? OFS_W'(-source_offset) : OFS_W'(source_offset);
	assign rdy_s1   = !vld_s1 || d1_in_ready;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			t2_s1   <= T2_W'(zero_offset_time) * T2_W'(zero_offset_time);
			x2_s1   <= X2_W'(xmag) * X2_W'(xmag);
			v2_s1   <= T2_W'(rms_velocity) * T2_W'(rms_velocity);
			last_s1 <= last_of_gather;
		end
	end

	// ------------------------------------------------------------------
	// divider 1: R = floor(x^2 * 2^32 / v^2); zero v or R >= 2^56 saturates
	// ------------------------------------------------------------------
	logic              sat0;
	logic              d1_out_valid;
	logic              rdy_s3;
	logic [R_W-1:0]    d1_quo;
	logic [SD1_W-1:0]  d1_side;

	assign sat0 = {(T2_W+24-X2_W)'(0), x2_s1} >= {v2_s1, 24'b0};

	nmo_div #(
		.QW    (R_W),
		.DW    (T2_W),
		.SW    (SD1_W),
		.STEPS (DIV_STEPS)
	) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (d1_in_ready),
		.in_rem    (T2_W'(x2_s1[X2_W-1:24])),
		.in_num    ({x2_s1[23:0], 32'b0}),
		.in_den    (v2_s1),
		.in_side   ({last_s1, sat0, t2_s1}),
		.out_valid (d1_out_valid),
		.out_ready (rdy_s3),
		.out_quo   (d1_quo),
		.out_side  (d1_side)
	);

	// ------------------------------------------------------------------
	// stage 3: t^2 sum, partial products of R^2 and |c|*R
	// ------------------------------------------------------------------
	logic                vld_s3;
	logic [S_W-1:0]      sum_s3;
	logic [T2_W-1:0]     t2_s3;
	logic [2*PART_W-1:0] hh_s3, hl_s3, ll_s3;
	logic [NP_W-1:0]     crh_s3, crl_s3;
	logic                sat_s3, last_s3;
	logic [PART_W-1:0]   rh, rl;
	logic                rdy_s4;

	assign rh     = d1_quo[R_W-1:PART_W];
	assign rl     = d1_quo[PART_W-1:0];
	assign rdy_s3 = !vld_s3 || rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= d1_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sum_s3  <= S_W'(d1_side[T2_W-1:0]) + S_W'(d1_quo);
			t2_s3   <= d1_side[T2_W-1:0];
			hh_s3   <= (2*PART_W)'(rh) * (2*PART_W)'(rh);
			hl_s3   <= (2*PART_W)'(rh) * (2*PART_W)'(rl);
			ll_s3   <= (2*PART_W)'(rl) * (2*PART_W)'(rl);
			crh_s3  <= NP_W'(rh) * NP_W'(cmag);
			crl_s3  <= NP_W'(rl) * NP_W'(cmag);
			sat_s3  <= d1_side[T2_W];
			last_s3 <= d1_side[T2_W+1];
		end
	end

	// ------------------------------------------------------------------
	// stage 4: R^2, denominator 4096*t0^2 + c*R and its sign
	// ------------------------------------------------------------------
	logic             vld_s4;
	logic [R2_W-1:0]  r2_s4;
	logic [D_W-1:0]   den_s4;
	logic             pos_s4;
	logic [S_W-1:0]   sum_s4;
	logic             sat_s4, last_s4;
	logic [QM_W-1:0]  qm;
	logic [D_W-1:0]   pt;
	logic             rdy_s5;

	assign qm     = (QM_W'(crh_s3) << PART_W) + QM_W'(crl_s3);
	assign pt     = D_W'({t2_s3, 12'b0});
	assign rdy_s4 = !vld_s4 || rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			r2_s4   <= (R2_W'(hh_s3) << (2*PART_W)) + (R2_W'(hl_s3) << (PART_W+1))
				+ R2_W'(ll_s3);
			den_s4  <= c_neg ? (pt - D_W'(qm)) : (pt + D_W'(qm));
			pos_s4  <= c_neg ? (D_W'(qm) < pt) : ((|t2_s3) || (|qm));
			sum_s4  <= sum_s3;
			sat_s4  <= sat_s3;
			last_s4 <= last_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: numerator partial products 2|eta| * R^2 slices
	// ------------------------------------------------------------------
	logic             vld_s5;
	logic [NP_W-1:0]  np_s5 [NPARTS];
	logic [D_W-1:0]   den_s5;
	logic             pos_s5;
	logic [S_W-1:0]   sum_s5;
	logic             sat_s5, last_s5;
	logic             rdy_s6;

	assign rdy_s5 = !vld_s5 || rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (rdy_s5) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			for (int i = 0; i < NPARTS; i++) begin
				np_s5[i] <= NP_W'(r2_s4[i*PART_W +: PART_W]) * NP_W'(emag2);
			end
			den_s5  <= den_s4;
			pos_s5  <= pos_s4;
			sum_s5  <= sum_s4;
			sat_s5  <= sat_s4;
			last_s5 <= last_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: numerator sum
	// ------------------------------------------------------------------
	logic             vld_s6;
	logic [N_W-1:0]   num_s6;
	logic [D_W-1:0]   den_s6;
	logic             pos_s6;
	logic [S_W-1:0]   sum_s6;
	logic             sat_s6, last_s6;
	logic [N_W-1:0]   num_c;
	logic             d2_in_ready;

	always_comb begin
		num_c = '0;
		for (int i = 0; i < NPARTS; i++) begin
			num_c = num_c + (N_W'(np_s5[i]) << (i * PART_W));
		end
	end

	assign rdy_s6 = !vld_s6 || d2_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			num_s6  <= num_c;
			den_s6  <= den_s5;
			pos_s6  <= pos_s5;
			sum_s6  <= sum_s5;
			sat_s6  <= sat_s5;
			last_s6 <= last_s5;
		end
	end

	// ------------------------------------------------------------------
	// divider 2: A = floor(N / D), clamped: ovf flags A >= 2^57
	// ------------------------------------------------------------------
	logic              ovf;
	logic              d2_out_valid;
	logic              rdy_s7;
	logic [A_W-1:0]    d2_quo;
	logic [SD2_W-1:0]  d2_side;

	assign ovf = D_W'(num_s6[N_W-1:A_W]) >= den_s6;

	nmo_div #(
		.QW    (A_W),
		.DW    (D_W),
		.SW    (SD2_W),
		.STEPS (DIV_STEPS)
	) u_div_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.in_ready  (d2_in_ready),
		.in_rem    (D_W'(num_s6[N_W-1:N_W-RDN_W])),
		.in_num    (num_s6[A_W-1:0]),
		.in_den    (den_s6),
		.in_side   ({last_s6, sat_s6, pos_s6, ovf, sum_s6}),
		.out_valid (d2_out_valid),
		.out_ready (rdy_s7),
		.out_quo   (d2_quo),
		.out_side  (d2_side)
	);

	// ------------------------------------------------------------------
	// stage 7: apply the correction
	// ------------------------------------------------------------------
	logic             vld_s7;
	logic [SF_W-1:0]  sf_s7;
	logic             sat_s7, last_s7;
	logic [S_W-1:0]   sum_d2;
	logic             ovf_d2, pos_d2;
	logic [SF_W-1:0]  sf_c;
	logic             sat_c;
	logic             sq_in_ready;

	assign sum_d2 = d2_side[S_W-1:0];
	assign ovf_d2 = d2_side[S_W];
	assign pos_d2 = d2_side[S_W+1];

	// with eta active and a positive denominator, positive eta subtracts A when it is below t^2; negative eta adds |A|
	always_comb begin
		sf_c  = SF_W'(sum_d2);
		sat_c = d2_side[S_W+2];
		if (eta_act && pos_d2) begin
			if (!eta_neg) begin
				if (!ovf_d2 && (d2_quo < sum_d2)) begin
					sf_c = SF_W'(sum_d2 - d2_quo);
				end
			end else begin
				if (ovf_d2 || (|d2_quo[A_W-1:T2_W])) begin
					sat_c = 1'b1;
				end
				sf_c = SF_W'(sum_d2) + SF_W'(d2_quo);
			end
		end
	end

	assign rdy_s7 = !vld_s7 || sq_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (rdy_s7) begin
			vld_s7 <= d2_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			sf_s7   <= sf_c;
			sat_s7  <= sat_c;
			last_s7 <= d2_side[S_W+3];
		end
	end

	// ------------------------------------------------------------------
	// square root; t^2 at or above 2^48 saturates
	// ------------------------------------------------------------------
	logic              sq_out_valid;
	logic              rdy_s9;
	logic [TIME_W-1:0] sq_root;
	logic [1:0]        sq_side;
	logic              sat_sq;

	assign sat_sq = sat_s7 || (|sf_s7[SF_W-1:T2_W]);

	nmo_sqrt #(
		.SW    (2),
		.STEPS (SQRT_STEPS)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s7),
		.in_ready  (sq_in_ready),
		.in_sq     (sf_s7[T2_W-1:0]),
		.in_side   ({last_s7, sat_sq}),
		.out_valid (sq_out_valid),
		.out_ready (rdy_s9),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// ------------------------------------------------------------------
	// stage 9: output register with saturation
	// ------------------------------------------------------------------
	logic              vld_s9;
	logic [TIME_W-1:0] mo_s9;
	logic              sat_s9, last_s9;

	assign rdy_s9 = !vld_s9 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (rdy_s9) begin
			vld_s9 <= sq_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s9) begin
			mo_s9   <= sq_side[0] ? '1 : sq_root;
			sat_s9  <= sq_side[0];
			last_s9 <= sq_side[1];
		end
	end

	assign out_valid    = vld_s9;
	assign moveout_time = mo_s9;
	assign saturated    = sat_s9;
	assign last_out     = last_s9;

endmodule

`default_nettype wire

@@ rtl/core/nmo_div.sv @@
// ---------------------------------------------------------------------------
// nmo_div: pipelined restoring divider
// Shifts QW numerator bits into a remainder and produces one quotient bit
// per step, STEPS steps per register stage. Starting remainder must be
// below the divisor. Side data travels with each item.
// ---------------------------------------------------------------------------
`default_nettype none

module nmo_div #(
	parameter int QW    = 56,
	parameter int DW    = 48,
	parameter int SW    = 1,
	parameter int STEPS = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [DW-1:0] in_rem,
	input  wire logic [QW-1:0] in_num,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [SW-1:0] in_side,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [QW-1:0]      out_quo,
	output logic [SW-1:0]      out_side
);

	localparam int NST = (QW + STEPS - 1) / STEPS;

	logic [NST-1:0] vld_s;
	logic [NST:0]   rdy;
	logic [DW-1:0]  rem_s  [NST];
	logic [QW-1:0]  nq_s   [NST];
	logic [DW-1:0]  den_s  [NST];
	logic [SW-1:0]  side_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic          vld_i;
		logic [DW-1:0] rem_i;
		logic [QW-1:0] nq_i;
		logic [DW-1:0] den_i;
		logic [SW-1:0] side_i;
		logic [DW-1:0] rem_c;
		logic [QW-1:0] nq_c;

		if (k == 0) begin : g_first
			assign vld_i  = in_valid;
			assign rem_i  = in_rem;
			assign nq_i   = in_num;
			assign den_i  = in_den;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign nq_i   = nq_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
		end

		// restoring steps: numerator bits leave the top, quotient bits enter the bottom
		always_comb begin
			logic [DW:0] tt;
			rem_c = rem_i;
			nq_c  = nq_i;
			tt    = '0;
			for (int i = 0; i < STEPS; i++) begin
				if (k * STEPS + i < QW) begin
					tt   = {rem_c, nq_c[QW-1]};
					nq_c = {nq_c[QW-2:0], 1'b0};
					if (tt >= {1'b0, den_i}) begin
						rem_c   = DW'(tt - {1'b0, den_i});
						nq_c[0] = 1'b1;
					end else begin
						rem_c = tt[DW-1:0];
					end
				end
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_s[k]  <= rem_c;
				nq_s[k]   <= nq_c;
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign rdy[NST]  = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NST-1];
	assign out_quo   = nq_s[NST-1];
	assign out_side  = side_s[NST-1];

endmodule

`default_nettype wire

@@ rtl/core/nmo_sqrt.sv @@
// ---------------------------------------------------------------------------
// nmo_sqrt: pipelined integer square root
// Digit-by-digit floor square root of a 48-bit word, STEPS result bits per
// register stage. Side data travels with each item.
// ---------------------------------------------------------------------------
`default_nettype none

module nmo_sqrt #(
	parameter int SW    = 2,
	parameter int STEPS = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [nmo_pkg::T2_W-1:0]   in_sq,
	input  wire logic [SW-1:0]              in_side,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [nmo_pkg::TIME_W-1:0]      out_root,
	output logic [SW-1:0]                   out_side
);

	localparam int SQ_W  = nmo_pkg::T2_W;
	localparam int ITERS = nmo_pkg::TIME_W;
	localparam int NST   = (ITERS + STEPS - 1) / STEPS;

	logic [NST-1:0]  vld_s;
	logic [NST:0]    rdy;
	logic [SQ_W-1:0] sq_s   [NST];
	logic [SQ_W-1:0] res_s  [NST];
	logic [SW-1:0]   side_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic            vld_i;
		logic [SQ_W-1:0] sq_i;
		logic [SQ_W-1:0] res_i;
		logic [SW-1:0]   side_i;
		logic [SQ_W-1:0] sq_c;
		logic [SQ_W-1:0] res_c;

		if (k == 0) begin : g_first
			assign vld_i  = in_valid;
			assign sq_i   = in_sq;
			assign res_i  = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign sq_i   = sq_s[k-1];
			assign res_i  = res_s[k-1];
			assign side_i = side_s[k-1];
		end

		// one trial subtract per result bit, test bit moves down two places
		always_comb begin
			logic [SQ_W-1:0] sb;
			logic [SQ_W:0]   tr;
			int              idx;
			sq_c  = sq_i;
			res_c = res_i;
			sb    = '0;
			tr    = '0;
			idx   = 0;
			for (int i = 0; i < STEPS; i++) begin
				idx = k * STEPS + i;
				if (idx < ITERS) begin
					sb = SQ_W'(1) << (SQ_W - 2 - 2 * idx);
					tr = {1'b0, res_c} + {1'b0, sb};
					if ({1'b0, sq_c} >= tr) begin
						sq_c  = SQ_W'({1'b0, sq_c} - tr);
						res_c = (res_c >> 1) + sb;
					end else begin
						res_c = res_c >> 1;
					end
				end
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				sq_s[k]   <= sq_c;
				res_s[k]  <= res_c;
				side_s[k] <= side_i;
			end
		end
	end

	assign rdy[NST]  = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NST-1];
	assign out_root  = res_s[NST-1][ITERS-1:0];
	assign out_side  = side_s[NST-1];

endmodule

`default_nettype wire
